// ===== rtl/core/fbpa_pkg.sv =====
// Shared widths, codes and types of the fixed-size block pool allocator.
`default_nettype none
package fbpa_pkg;

	localparam int unsigned MAX_BLOCKS_DEF = 1024;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned BSZ_W  = 17;
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned SZ_W   = BSZ_W + 1;
	localparam int unsigned SPAN_W = CNT_W + SZ_W;
	localparam int unsigned IDXR_W = 2;

	localparam logic [ADDR_W-1:0] RST_BASE  = '0;
	localparam logic [BSZ_W-1:0]  RST_SIZE  = BSZ_W'(32);
	localparam logic [CNT_W-1:0]  RST_COUNT = CNT_W'(16);

	typedef enum logic [IDXR_W-1:0] {
		REG_BASE  = 2'd0,
		REG_SIZE  = 2'd1,
		REG_COUNT = 2'd2
	} fbpa_reg_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_BAD_ADDR = 2'd2,
		ST_FULL     = 2'd3
	} fbpa_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GET_DEC,
		S_GET_LINK,
		S_GET_MUL,
		S_GET_ADD,
		S_PUT_SPAN,
		S_PUT_CHECK,
		S_PUT_DIV
	} fbpa_state_t;

	typedef struct packed {
		logic         pop_head;
		logic         take_fresh;
		logic         load_link;
		logic         mul_en;
		logic         mul_count;
		logic         div_go;
		logic         push;
		logic         grant;
		logic         finish;
		fbpa_status_t status;
	} fbpa_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// Top level of the fixed-size block pool allocator.
//
// A pool of equal blocks starts at base_address. A command beat is taken when
// start is high and busy is low: op 0 gets a block from the head of a LIFO
// free list (never-allocated blocks come from a watermark once the list is
// empty), op 1 puts a block back after range, alignment and pool-full checks.
// Each command gives one result beat: done is high for exactly one cycle with
// granted_address, status, free_count and used_count; the receiver cannot
// stall, so the result must be taken in that cycle.
// A get that finds no block ends in the decode state; a get from the watermark
// goes on through the multiply and add states, and a get from the list reads the
// link memory first. A put outside the pool span ends after the span check; any
// other put runs the eleven-step divider that finds the block index and checks
// alignment. busy is low again in the cycle done is high.
// The list links live in one synchronous memory, read in the cycle after the
// address is presented; commands run one at a time, so no access overlaps.
// Configuration writes (wr_en, wr_index, wr_data) to index 0-2 land at once
// and re-create the pool like reset: list empty, watermark zero, all blocks free.
`default_nettype none
module fixed_block_pool_allocator #(
	parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          op,
	input  wire logic [fbpa_pkg::ADDR_W-1:0]   block_address,
	input  wire logic                          wr_en,
	input  wire logic [fbpa_pkg::IDXR_W-1:0]   wr_index,
	input  wire logic [fbpa_pkg::ADDR_W-1:0]   wr_data,
	output logic                               done,
	output logic [fbpa_pkg::ADDR_W-1:0]        granted_address,
	output logic [1:0]                         status,
	output logic [fbpa_pkg::CNT_W-1:0]         free_count,
	output logic [fbpa_pkg::CNT_W-1:0]         used_count
);

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = fbpa_pkg::CNT_W;
	localparam int unsigned SZ_W  = fbpa_pkg::SZ_W;

	function automatic logic [CNT_W-1:0] eff_cnt_f(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (32'(c) > 32'(MAX_BLOCKS)) begin
			r = CNT_W'(MAX_BLOCKS);
		end
		return r;
	endfunction

	function automatic logic [SZ_W-1:0] eff_sz_f(input logic [fbpa_pkg::BSZ_W-1:0] b);
		logic [SZ_W-1:0] s;
		s = (SZ_W'(b) + SZ_W'(3)) & ~SZ_W'(3);
		if (s < SZ_W'(4)) begin
			s = SZ_W'(4);
		end
		return s;
	endfunction

	// Configuration
	logic [fbpa_pkg::ADDR_W-1:0] base_q, base_nxt;
	logic [fbpa_pkg::BSZ_W-1:0]  size_q, size_nxt;
	logic [CNT_W-1:0]            count_q, count_nxt;
	logic                        create;
	logic [CNT_W-1:0]            eff_cnt;
	logic [SZ_W-1:0]             eff_sz;

	// Pool state
	fbpa_pkg::fbpa_state_t       state_q, state_nxt;
	fbpa_pkg::fbpa_ctrl_t        ctrl;
	logic [IDX_W-1:0]            head_q;
	logic                        head_vld_q;
	logic [CNT_W-1:0]            fresh_q;
	logic [CNT_W-1:0]            free_q, free_nxt;
	logic [IDX_W:0]              link_mem [MAX_BLOCKS];
	logic [IDX_W:0]              link_rd_q;

	// Command datapath
	logic                        op_q;
	logic [fbpa_pkg::ADDR_W-1:0] addr_q;
	logic [fbpa_pkg::ADDR_W-1:0] off_q;
	logic                        below_q;
	logic [IDX_W-1:0]            idx_q;
	logic [CNT_W-1:0]            mul_a;
	logic [fbpa_pkg::SPAN_W-1:0] mul_q;
	logic                        out_of_range;
	logic                        pool_full;
	logic                        have_free;
	logic                        fresh_ok;
	logic                        div_done;
	logic [CNT_W-1:0]            div_quot;
	logic                        div_rem_nz;

	// Result
	logic                        done_q;
	logic [fbpa_pkg::ADDR_W-1:0] res_addr_q;
	fbpa_pkg::fbpa_status_t      res_status_q;
	logic [CNT_W-1:0]            res_free_q;
	logic [CNT_W-1:0]            res_used_q;

	always_comb begin
		base_nxt  = base_q;
		size_nxt  = size_q;
		count_nxt = count_q;
		create    = 1'b0;
		if (wr_en) begin
			unique case (wr_index)
				fbpa_pkg::REG_BASE: begin
					base_nxt = wr_data;
					create   = 1'b1;
				end
				fbpa_pkg::REG_SIZE: begin
					size_nxt = wr_data[fbpa_pkg::BSZ_W-1:0];
					create   = 1'b1;
				end
				fbpa_pkg::REG_COUNT: begin
					count_nxt = wr_data[CNT_W-1:0];
					create    = 1'b1;
				end
				default: begin
					create = 1'b0;
				end
			endcase
		end
	end

	assign eff_cnt = eff_cnt_f(count_q);
	assign eff_sz  = eff_sz_f(size_q);

	assign have_free    = free_q != '0;
	assign fresh_ok     = fresh_q < eff_cnt;
	assign pool_full    = free_q >= eff_cnt;
	assign out_of_range = below_q || (off_q >= fbpa_pkg::ADDR_W'(mul_q));
	assign busy         = state_q != fbpa_pkg::S_IDLE;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fbpa_pkg::S_IDLE: begin
				if (start) begin
					state_nxt = op ? fbpa_pkg::S_PUT_SPAN : fbpa_pkg::S_GET_DEC;
				end
			end
			fbpa_pkg::S_GET_DEC: begin
				if (have_free && head_vld_q) begin
					state_nxt = fbpa_pkg::S_GET_LINK;
				end else if (have_free && fresh_ok) begin
					state_nxt = fbpa_pkg::S_GET_MUL;
				end else begin
					state_nxt = fbpa_pkg::S_IDLE;
				end
			end
			fbpa_pkg::S_GET_LINK:  state_nxt = fbpa_pkg::S_GET_MUL;
			fbpa_pkg::S_GET_MUL:   state_nxt = fbpa_pkg::S_GET_ADD;
			fbpa_pkg::S_GET_ADD:   state_nxt = fbpa_pkg::S_IDLE;
			fbpa_pkg::S_PUT_SPAN:  state_nxt = fbpa_pkg::S_PUT_CHECK;
			fbpa_pkg::S_PUT_CHECK: begin
				state_nxt = out_of_range ? fbpa_pkg::S_IDLE : fbpa_pkg::S_PUT_DIV;
			end
			fbpa_pkg::S_PUT_DIV: begin
				if (div_done) begin
					state_nxt = fbpa_pkg::S_IDLE;
				end
			end
			default: state_nxt = fbpa_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		ctrl        = '0;
		ctrl.status = fbpa_pkg::ST_OK;
		unique case (state_q)
			fbpa_pkg::S_GET_DEC: begin
				if (have_free && head_vld_q) begin
					ctrl.pop_head = 1'b1;
				end else if (have_free && fresh_ok) begin
					ctrl.take_fresh = 1'b1;
				end else begin
					ctrl.finish = 1'b1;
					ctrl.status = fbpa_pkg::ST_NO_FREE;
				end
			end
			fbpa_pkg::S_GET_LINK: ctrl.load_link = 1'b1;
			fbpa_pkg::S_GET_MUL:  ctrl.mul_en = 1'b1;
			fbpa_pkg::S_GET_ADD: begin
				ctrl.grant  = 1'b1;
				ctrl.finish = 1'b1;
			end
			fbpa_pkg::S_PUT_SPAN: begin
				ctrl.mul_en    = 1'b1;
				ctrl.mul_count = 1'b1;
			end
			fbpa_pkg::S_PUT_CHECK: begin
				if (out_of_range) begin
					ctrl.finish = 1'b1;
					ctrl.status = fbpa_pkg::ST_BAD_ADDR;
				end else begin
					ctrl.div_go = 1'b1;
				end
			end
			fbpa_pkg::S_PUT_DIV: begin
				if (div_done) begin
					ctrl.finish = 1'b1;
					if (div_rem_nz) begin
						ctrl.status = fbpa_pkg::ST_BAD_ADDR;
					end else if (pool_full) begin
						ctrl.status = fbpa_pkg::ST_FULL;
					end else begin
						ctrl.push = 1'b1;
					end
				end
			end
			default: ctrl.finish = 1'b0;
		endcase
	end

	always_comb begin
		free_nxt = free_q;
		if (ctrl.take_fresh || ctrl.load_link) begin
			free_nxt = free_q - 1'b1;
		end else if (ctrl.push) begin
			free_nxt = free_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fbpa_pkg::S_IDLE;
			base_q     <= fbpa_pkg::RST_BASE;
			size_q     <= fbpa_pkg::RST_SIZE;
			count_q    <= fbpa_pkg::RST_COUNT;
			head_vld_q <= 1'b0;
			head_q     <= '0;
			fresh_q    <= '0;
			free_q     <= eff_cnt_f(fbpa_pkg::RST_COUNT);
			done_q     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			base_q  <= base_nxt;
			size_q  <= size_nxt;
			count_q <= count_nxt;
			done_q  <= ctrl.finish;
			if (create) begin
				// rebuild the pool: empty list, fresh watermark
				head_vld_q <= 1'b0;
				fresh_q    <= '0;
				free_q     <= eff_cnt_f(count_nxt);
			end else begin
				free_q <= free_nxt;
				if (ctrl.take_fresh) begin
					fresh_q <= fresh_q + 1'b1;
				end
				if (ctrl.load_link) begin
					{head_vld_q, head_q} <= link_rd_q;
				end else if (ctrl.push) begin
					head_vld_q <= 1'b1;
					head_q     <= IDX_W'(div_quot);
				end
			end
		end
	end

	// Link memory: one write or one read a cycle, read data registered
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			link_mem[IDX_W'(div_quot)] <= {head_vld_q, head_q};
		end
		if (ctrl.pop_head) begin
			link_rd_q <= link_mem[head_q];
		end
	end

	assign mul_a = ctrl.mul_count ? eff_cnt : CNT_W'(idx_q);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q   <= op;
			addr_q <= block_address;
		end
		if (state_q == fbpa_pkg::S_PUT_SPAN) begin
			off_q   <= addr_q - base_q;
			below_q <= addr_q < base_q;
		end
		if (ctrl.pop_head) begin
			idx_q <= head_q;
		end else if (ctrl.take_fresh) begin
			idx_q <= IDX_W'(fresh_q);
		end
		if (ctrl.mul_en) begin
			mul_q <= fbpa_pkg::SPAN_W'(mul_a * eff_sz);
		end
		if (ctrl.finish) begin
			res_addr_q   <= ctrl.grant ? base_q + fbpa_pkg::ADDR_W'(mul_q) : '0;
			res_status_q <= ctrl.status;
			res_free_q   <= free_nxt;
			res_used_q   <= eff_cnt - free_nxt;
		end
	end

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (ctrl.div_go),
		.dividend (off_q[fbpa_pkg::SPAN_W-1:0]),
		.divisor  (eff_sz),
		.done     (div_done),
		.quotient (div_quot),
		.rem_nz   (div_rem_nz)
	);

	assign done            = done_q;
	assign granted_address = res_addr_q;
	assign status          = res_status_q;
	assign free_count      = res_free_q;
	assign used_count      = res_used_q;

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= eff_cnt)
		else $error("free count above pool size");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= eff_cnt)
		else $error("watermark past end of pool");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_grant_put: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.push || ctrl.div_go) |-> op_q)
		else $error("put datapath used by a get");

endmodule
`default_nettype wire

// ===== rtl/core/fbpa_div.sv =====
// Restoring divider: one quotient bit a cycle, MSB first.
`default_nettype none
module fbpa_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic [fbpa_pkg::SPAN_W-1:0]  dividend,
	input  wire logic [fbpa_pkg::SZ_W-1:0]    divisor,
	output logic                              done,
	output logic [fbpa_pkg::CNT_W-1:0]        quotient,
	output logic                              rem_nz
);

	localparam int unsigned STEP_W = $clog2(fbpa_pkg::CNT_W);

	logic [fbpa_pkg::SPAN_W-1:0] rem_q;
	logic [fbpa_pkg::SPAN_W-1:0] dvs_q;
	logic [fbpa_pkg::CNT_W-1:0]  quot_q;
	logic [STEP_W-1:0]           step_q;
	logic                        run_q;
	logic                        done_q;
	logic                        ge;

	// The quotient fits CNT_W bits as the dividend lies below the pool span.
	assign ge = rem_q >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(fbpa_pkg::CNT_W - 1);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= dividend;
			dvs_q  <= fbpa_pkg::SPAN_W'(divisor) << (fbpa_pkg::CNT_W - 1);
			quot_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quot_q <= {quot_q[fbpa_pkg::CNT_W-2:0], ge};
			dvs_q  <= dvs_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;
	assign rem_nz   = rem_q != '0;

endmodule
`default_nettype wire

// ===== tb/sv/fixed_block_pool_allocator_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the fixed-size block pool allocator: command beats, pool predictor.
module fixed_block_pool_allocator_test;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;
	localparam logic [fbpa_pkg::IDXR_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned NO_LINK = fbpa_pkg::MAX_BLOCKS_DEF;

	typedef struct packed {
		logic                        cfg;
		logic                        may_idle;
		logic                        op;
		logic [fbpa_pkg::ADDR_W-1:0] addr;
		logic [fbpa_pkg::IDXR_W-1:0] reg_idx;
		logic [fbpa_pkg::ADDR_W-1:0] reg_data;
	} cmd_t;

	typedef struct packed {
		logic [fbpa_pkg::ADDR_W-1:0] granted;
		fbpa_pkg::fbpa_status_t      status;
		logic [fbpa_pkg::CNT_W-1:0]  free_n;
		logic [fbpa_pkg::CNT_W-1:0]  used_n;
	} reply_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        op = 1'b0;
	logic [fbpa_pkg::ADDR_W-1:0] block_address = '0;
	logic                        wr_en = 1'b0;
	logic [fbpa_pkg::IDXR_W-1:0] wr_index = '0;
	logic [fbpa_pkg::ADDR_W-1:0] wr_data = '0;
	logic                        busy;
	logic                        done;
	logic [fbpa_pkg::ADDR_W-1:0] granted_address;
	logic [1:0]                  status;
	logic [fbpa_pkg::CNT_W-1:0]  free_count;
	logic [fbpa_pkg::CNT_W-1:0]  used_count;

	cmd_t   cmd_q[$];
	reply_t pool_replies[$];
	logic   item_taken = 1'b0;
	logic   fail_seen = 1'b0;
	int     gap_left = 0;
	int     items_made = 0;

	// predictor copy of the registers and the pool
	logic [fbpa_pkg::ADDR_W-1:0] pool_base;
	logic [fbpa_pkg::BSZ_W-1:0]  pool_bsize;
	logic [fbpa_pkg::CNT_W-1:0]  pool_bcount;
	int unsigned                 head_idx;
	int unsigned                 next_fresh;
	int unsigned                 free_n;
	int unsigned                 chain [fbpa_pkg::MAX_BLOCKS_DEF];

	// register values as written so far, for building addresses
	logic [fbpa_pkg::ADDR_W-1:0] gen_base;
	logic [fbpa_pkg::BSZ_W-1:0]  gen_size;
	logic [fbpa_pkg::CNT_W-1:0]  gen_count;

	fixed_block_pool_allocator u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.block_address   (block_address),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.done            (done),
		.granted_address (granted_address),
		.status          (status),
		.free_count      (free_count),
		.used_count      (used_count)
	);

	always #5 clk = ~clk;

	function automatic int unsigned size_eff(logic [fbpa_pkg::BSZ_W-1:0] raw);
		int unsigned s;
		s = raw;
		s = (s + 3) & ~32'd3;
		return (s < 4) ? 4 : s;
	endfunction

	function automatic int unsigned count_eff(logic [fbpa_pkg::CNT_W-1:0] raw);
		int unsigned c;
		c = raw;
		return (c > fbpa_pkg::MAX_BLOCKS_DEF) ? fbpa_pkg::MAX_BLOCKS_DEF : c;
	endfunction

	function automatic logic [fbpa_pkg::ADDR_W-1:0] block_at(logic [fbpa_pkg::ADDR_W-1:0] b,
			int unsigned k, int unsigned sz);
		logic [63:0] a;
		a = {32'd0, b} + {32'd0, k} * {32'd0, sz};
		return a[fbpa_pkg::ADDR_W-1:0];
	endfunction

	task automatic pool_rebuild();
		head_idx = NO_LINK;
		next_fresh = 0;
		free_n = count_eff(pool_bcount);
	endtask

	task automatic pool_write(logic [fbpa_pkg::IDXR_W-1:0] idx, logic [fbpa_pkg::ADDR_W-1:0] d);
		logic hit;
		hit = 1'b1;
		case (idx)
			fbpa_pkg::REG_BASE: pool_base = d;
			fbpa_pkg::REG_SIZE: pool_bsize = d[fbpa_pkg::BSZ_W-1:0];
			fbpa_pkg::REG_COUNT: pool_bcount = d[fbpa_pkg::CNT_W-1:0];
			default: hit = 1'b0;
		endcase
		if (hit)
			pool_rebuild();
	endtask

	function automatic reply_t pool_serve(logic op_in, logic [fbpa_pkg::ADDR_W-1:0] a);
		reply_t      r;
		int unsigned sz;
		int unsigned cnt;
		int unsigned idx;
		logic        got;
		logic [63:0] span;
		logic [63:0] off;
		logic [63:0] quo;
		sz = size_eff(pool_bsize);
		cnt = count_eff(pool_bcount);
		r.granted = '0;
		r.status = fbpa_pkg::ST_OK;
		got = 1'b0;
		idx = 0;
		if (op_in == OP_GET) begin
			if (free_n != 0) begin
				if (head_idx < NO_LINK) begin
					idx = head_idx;
					head_idx = chain[idx];
					got = 1'b1;
				end else if (next_fresh < cnt) begin
					idx = next_fresh;
					next_fresh++;
					got = 1'b1;
				end
			end
			if (got) begin
				free_n--;
				r.granted = block_at(pool_base, idx, sz);
			end else
				r.status = fbpa_pkg::ST_NO_FREE;
		end else begin
			span = {32'd0, cnt} * {32'd0, sz};
			if (a < pool_base)
				r.status = fbpa_pkg::ST_BAD_ADDR;
			else begin
				off = {32'd0, a - pool_base};
				if (off >= span || (off % {32'd0, sz}) != 0)
					r.status = fbpa_pkg::ST_BAD_ADDR;
				else if (free_n >= cnt)
					r.status = fbpa_pkg::ST_FULL;
				else begin
					quo = off / {32'd0, sz};
					idx = quo[31:0];
					chain[idx] = head_idx;
					head_idx = idx;
					free_n++;
				end
			end
		end
		r.free_n = free_n[fbpa_pkg::CNT_W-1:0];
		r.used_n = fbpa_pkg::CNT_W'(cnt - free_n);
		return r;
	endfunction

	task automatic add_cmd(logic o, logic [fbpa_pkg::ADDR_W-1:0] a, logic idle_ok);
		cmd_t c;
		c = '0;
		c.op = o;
		c.addr = a;
		c.may_idle = idle_ok;
		cmd_q.push_back(c);
		items_made++;
	endtask

	task automatic add_cfg(logic [fbpa_pkg::IDXR_W-1:0] idx, logic [fbpa_pkg::ADDR_W-1:0] d);
		cmd_t c;
		c = '0;
		c.cfg = 1'b1;
		c.reg_idx = idx;
		c.reg_data = d;
		cmd_q.push_back(c);
		case (idx)
			fbpa_pkg::REG_BASE: gen_base = d;
			fbpa_pkg::REG_SIZE: gen_size = d[fbpa_pkg::BSZ_W-1:0];
			fbpa_pkg::REG_COUNT: gen_count = d[fbpa_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Mostly get bursts and puts of in-range blocks, with some bad addresses mixed in.
	task automatic run_phase(int n_items, logic idle_ok);
		int unsigned                 sz;
		int unsigned                 cnt;
		int unsigned                 len;
		int unsigned                 lim;
		int unsigned                 k;
		int                          made;
		logic [fbpa_pkg::ADDR_W-1:0] a;
		logic                        spare_done;
		sz = size_eff(gen_size);
		cnt = count_eff(gen_count);
		lim = (cnt < 20) ? cnt + 2 : 20;
		made = 0;
		spare_done = ($urandom_range(0, 3) != 0);
		while (made < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					len = $urandom_range(1, lim);
					repeat (len) add_cmd(OP_GET, $urandom, idle_ok);
				end
				4, 5, 6, 7: begin
					len = $urandom_range(1, lim);
					repeat (len) begin
						k = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
						add_cmd(OP_PUT, block_at(gen_base, k, sz), idle_ok);
					end
				end
				default: begin
					len = 1;
					k = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
					case ($urandom_range(0, 3))
						0: a = $urandom;
						1: a = block_at(gen_base, k, sz) + $urandom_range(1, sz - 1);
						2: a = gen_base - $urandom_range(1, 64);
						default: a = block_at(gen_base, cnt, sz);
					endcase
					add_cmd(OP_PUT, a, idle_ok);
				end
			endcase
			made += len;
			// the unused index must leave the pool as it stands
			if (!spare_done && made >= n_items / 2) begin
				add_cfg(REG_SPARE, $urandom);
				spare_done = 1'b1;
			end
		end
	endtask

	task automatic phase_at(logic [fbpa_pkg::ADDR_W-1:0] b, logic [fbpa_pkg::ADDR_W-1:0] s,
			logic [fbpa_pkg::ADDR_W-1:0] n_blk, int n_items, logic idle_ok);
		add_cfg(fbpa_pkg::REG_BASE, b);
		add_cfg(fbpa_pkg::REG_SIZE, s);
		add_cfg(fbpa_pkg::REG_COUNT, n_blk);
		run_phase(n_items, idle_ok);
	endtask

	// Driver: one command beat or one register write at a time.
	always @(negedge clk) begin
		logic raise;
		logic pulse;
		cmd_t c;
		raise = start && !item_taken;
		pulse = 1'b0;
		if (arst_n && !raise) begin
			if (gap_left != 0)
				gap_left--;
			else if (cmd_q.size() != 0) begin
				c = cmd_q[0];
				if (!c.cfg) begin
					raise = 1'b1;
					op <= c.op;
					block_address <= c.addr;
					void'(cmd_q.pop_front());
					if (c.may_idle && $urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 7);
				end else if (pool_replies.size() == 0 && !busy) begin
					// write only once every result is home
					pulse = 1'b1;
					wr_index <= c.reg_idx;
					wr_data <= c.reg_data;
					void'(cmd_q.pop_front());
				end
			end
		end
		start <= raise;
		wr_en <= pulse;
	end

	// Monitor: check result beats, then predict for any beat taken at this edge.
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			pool_base = fbpa_pkg::RST_BASE;
			pool_bsize = fbpa_pkg::RST_SIZE;
			pool_bcount = fbpa_pkg::RST_COUNT;
			pool_rebuild();
			item_taken <= 1'b0;
		end else begin
			if (done) begin
				if (pool_replies.size() == 0) begin
					$display("%0t: result beat with none expected: addr %h status %0d free %0d used %0d",
						$time, granted_address, status, free_count, used_count);
					fail_seen = 1'b1;
				end else begin
					want = pool_replies.pop_front();
					if (granted_address !== want.granted) begin
						$display("%0t: granted_address expected %h, got %h",
							$time, want.granted, granted_address);
						fail_seen = 1'b1;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $time, want.status, status);
						fail_seen = 1'b1;
					end
					if (free_count !== want.free_n) begin
						$display("%0t: free_count expected %0d, got %0d",
							$time, want.free_n, free_count);
						fail_seen = 1'b1;
					end
					if (used_count !== want.used_n) begin
						$display("%0t: used_count expected %0d, got %0d",
							$time, want.used_n, used_count);
						fail_seen = 1'b1;
					end
				end
			end
			if (wr_en)
				pool_write(wr_index, wr_data);
			if (start && !busy)
				pool_replies.push_back(pool_serve(op, block_address));
			item_taken <= start && !busy;
		end
	end

	initial begin
		logic [fbpa_pkg::ADDR_W-1:0] rb;
		logic [fbpa_pkg::ADDR_W-1:0] rs;
		logic [fbpa_pkg::ADDR_W-1:0] rc;
		gen_base = fbpa_pkg::RST_BASE;
		gen_size = fbpa_pkg::RST_SIZE;
		gen_count = fbpa_pkg::RST_COUNT;

		// pool as reset: base 0, 32-byte blocks, 16 of them
		add_cmd(OP_PUT, 32'h0000_0000, 1'b1);
		add_cmd(OP_PUT, 32'hFFFF_FFFF, 1'b1);
		add_cmd(OP_PUT, 32'h0000_0004, 1'b1);
		add_cmd(OP_PUT, 32'h0000_0200, 1'b1);
		add_cmd(OP_GET, 32'hFFFF_FFFF, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);
		add_cmd(OP_PUT, 32'h0000_0020, 1'b1);
		add_cmd(OP_PUT, 32'h0000_0000, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);

		// two-block pool: below base, exhaustion, the same block put twice
		add_cfg(fbpa_pkg::REG_BASE, 32'h0000_0100);
		add_cfg(fbpa_pkg::REG_COUNT, 32'd2);
		add_cmd(OP_PUT, 32'h0000_00FF, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);
		add_cmd(OP_PUT, 32'h0000_0120, 1'b1);
		add_cmd(OP_PUT, 32'h0000_0120, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);
		add_cmd(OP_GET, 32'h0000_0000, 1'b1);
		add_cmd(OP_PUT, 32'h0000_0140, 1'b1);

		// register extremes: rounding, empty and single pools, saturation, wrap
		phase_at(32'h0000_0000, 32'd4, 32'd2, 70, 1'b1);
		phase_at(32'h8000_0000, 32'd0, 32'd0, 40, 1'b1);
		phase_at(32'hFFFF_FFFC, 32'd3, 32'd1, 60, 1'b1);
		phase_at(32'h1234_0000, 32'h0001_FFFF, 32'd1024, 80, 1'b1);
		phase_at(32'hFFFF_F000, 32'd32, 32'd300, 80, 1'b1);
		phase_at(32'h0000_0040, 32'd65536, 32'd2047, 70, 1'b1);
		phase_at(32'h0000_1001, 32'd5, 32'd7, 70, 1'b1);

		while (items_made < 1500) begin
			case ($urandom_range(0, 3))
				0: rb = '0;
				1: rb = $urandom;
				2: rb = 32'hFFFF_FFFF - $urandom_range(0, 4096);
				default: rb = $urandom_range(0, 65535);
			endcase
			case ($urandom_range(0, 4))
				0: rs = $urandom_range(0, 16);
				1: rs = $urandom;
				2: rs = 32'h0001_FFFF;
				default: rs = $urandom_range(4, 256);
			endcase
			case ($urandom_range(0, 5))
				0: rc = $urandom_range(25, 2047);
				1: rc = $urandom;
				default: rc = $urandom_range(0, 24);
			endcase
			phase_at(rb, rs, rc, $urandom_range(60, 160), 1'b1);
		end
		// closing stretch at full rate
		phase_at($urandom_range(0, 65535), 32'd16, 32'd12, 200, 1'b0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start || wr_en || pool_replies.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (!fail_seen)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
